@@ hw/rtl/crs_pkg.sv @@
// Shared widths, defaults and codes for the clipped running statistics core.
`default_nettype none

package crs_pkg;

    // Parameter defaults
    localparam int DURATION_BITS_DEF = 40;
    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed report widths
    localparam int CALL_W  = 32;
    localparam int EVENT_W = 48;
    localparam int TICK_W  = 56;
    localparam int TIME_W  = 56;
    localparam int SS_W    = 64;
    localparam int CLIP_W  = 8;

    // Sum of squares value 1.0 in Q56.8
    localparam logic [SS_W-1:0] SS_ONE = 64'd256;

    // Configuration register indexes
    localparam logic [0:0] REG_FILTER_ENABLE = 1'b0;
    localparam logic [0:0] REG_CLIP_K        = 1'b1;

    localparam logic              FILTER_ENABLE_RST = 1'b1;
    localparam logic [CLIP_W-1:0] CLIP_K_RST        = 8'd100;

    // Request commands
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/clipped_running_stats_core.sv @@
// Running timing statistics with sigma clipping, built on a shared bit-serial unit.
//
// Input channel: in_valid / in_stall carries command, duration_ticks and
// event_count; a request is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall carries one report per request.
// Config channel: cfg_valid / cfg_ready writes filter_enable (index 0) and
// clip_k_squared (index 1); cfg_ready is always high.
// A clear or a zero-count add goes from acceptance straight to the done state.
// An add runs a restoring divide (one quotient bit per cycle, DIV_W steps),
// then, when the outlier test needs it, two shift-add multiplies (56 and 48
// steps), and for a kept sample a multiply, a second divide and two more
// multiplies. Every request ends in the done state, from which out_valid is
// registered; one request is in flight at a time, and the next request can
// be taken from the cycle in which out_valid rises.
// The report sits in an output register: while out_stall is high it holds,
// and a finished request waits in its last state without taking another.
// Reset clears all statistics (minimum to all ones), sets filter_enable to 1
// and clip_k_squared to 100 (6.25).
`default_nettype none

module clipped_running_stats_core
    import crs_pkg::*;
#(
    parameter int DURATION_BITS = DURATION_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // request channel
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     command,
    input  wire logic [DURATION_BITS-1:0] duration_ticks,
    input  wire logic [COUNT_BITS-1:0]    event_count,
    // report channel
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [CALL_W-1:0]             report_calls,
    output logic [EVENT_W-1:0]            report_events,
    output logic [TICK_W-1:0]             report_ticks,
    output logic [TIME_W-1:0]             report_min,
    output logic [TIME_W-1:0]             report_max,
    output logic [CALL_W-1:0]             report_kept_calls,
    output logic [EVENT_W-1:0]            report_kept_events,
    output logic [TIME_W-1:0]             report_mean,
    output logic [SS_W-1:0]               report_sum_squares,
    output logic                          sample_kept,
    // configuration channel
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [CLIP_W-1:0]        cfg_data
);

    localparam int D1_W     = DURATION_BITS + FRACTION_BITS;
    localparam int D2_W     = TIME_W + COUNT_BITS;
    localparam int DIV_W    = (D1_W > D2_W) ? D1_W : D2_W;
    localparam int REM_W    = EVENT_W + 1;
    localparam int ACC_W    = 2 * TIME_W + EVENT_W;
    localparam int MY_W     = TIME_W;
    localparam int ITER_W   = 8;
    localparam int SS_SHIFT = 2 * FRACTION_BITS - 8;
    localparam int SH_R     = (2 * FRACTION_BITS >= 12) ? 2 * FRACTION_BITS - 12 : 0;
    localparam int SH_L     = (2 * FRACTION_BITS < 12) ? 12 - 2 * FRACTION_BITS : 0;
    localparam int SSK_W    = SS_W + CLIP_W;
    localparam int CMP_W    = ACC_W + 40;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV1 = 4'd1;
    localparam logic [3:0] S_FILT = 4'd2;
    localparam logic [3:0] S_MULA = 4'd3;
    localparam logic [3:0] S_MULB = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_KEEP = 4'd6;
    localparam logic [3:0] S_MULC = 4'd7;
    localparam logic [3:0] S_DIV2 = 4'd8;
    localparam logic [3:0] S_MULD = 4'd9;
    localparam logic [3:0] S_MULE = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    localparam logic [CALL_W-1:0]  CALL_MAX  = {CALL_W{1'b1}};
    localparam logic [EVENT_W-1:0] EVENT_MAX = {EVENT_W{1'b1}};
    localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [SS_W-1:0]    SS_MAX    = {SS_W{1'b1}};

    // control
    logic [3:0]              state_reg, state_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    filter_enable_reg, filter_enable_next;
    logic [CLIP_W-1:0]       clip_k_reg, clip_k_next;

    // statistics
    logic [CALL_W-1:0]       calls_reg, calls_next;
    logic [EVENT_W-1:0]      events_reg, events_next;
    logic [TICK_W-1:0]       ticks_reg, ticks_next;
    logic [TIME_W-1:0]       min_reg, min_next;
    logic [TIME_W-1:0]       max_reg, max_next;
    logic [CALL_W-1:0]       kcalls_reg, kcalls_next;
    logic [EVENT_W-1:0]      kevents_reg, kevents_next;
    logic [TIME_W-1:0]       mean_reg, mean_next;
    logic [SS_W-1:0]         ss_reg, ss_next;

    // item working registers
    logic [DURATION_BITS-1:0] dur_reg, dur_next;
    logic [COUNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]        fv_reg, fv_next;
    logic [TIME_W-1:0]        mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [EVENT_W-1:0]       newcnt_reg, newcnt_next;
    logic                     kept_reg, kept_next;

    // serial unit
    logic [DIV_W-1:0]        dq_reg, dq_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [EVENT_W-1:0]      dvsr_reg, dvsr_next;
    logic [ACC_W-1:0]        mx_reg, mx_next;
    logic [MY_W-1:0]         my_reg, my_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;

    // report snapshot
    logic [CALL_W-1:0]       r_calls_reg;
    logic [EVENT_W-1:0]      r_events_reg;
    logic [TICK_W-1:0]       r_ticks_reg;
    logic [TIME_W-1:0]       r_min_reg;
    logic [TIME_W-1:0]       r_max_reg;
    logic [CALL_W-1:0]       r_kcalls_reg;
    logic [EVENT_W-1:0]      r_kevents_reg;
    logic [TIME_W-1:0]       r_mean_reg;
    logic [SS_W-1:0]         r_ss_reg;
    logic                    r_kept_reg;
    logic                    snap_load;

    // datapath helpers
    logic                    in_take;
    logic [REM_W-1:0]        rem_shift;
    logic                    div_ge;
    logic [ACC_W-1:0]        acc_step;
    logic [TIME_W-1:0]       quot_sat;
    logic [TIME_W-1:0]       q_mean;
    logic [TIME_W-1:0]       mean_upd;
    logic [TIME_W-1:0]       dev2;
    logic [SSK_W-1:0]        ssk;
    logic [CMP_W-1:0]        cmp_l;
    logic [CMP_W-1:0]        cmp_r;
    logic [ACC_W-1:0]        ss_shifted;
    logic [SS_W-1:0]         ss_inc;
    logic [SS_W:0]           ss_sum;
    logic [EVENT_W:0]        ev_sum;
    logic [EVENT_W:0]        kev_sum;
    logic [TICK_W:0]         tick_sum;
    logic                    trivial_keep;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // One restoring divide step
    assign rem_shift = {rem_reg[REM_W-2:0], dq_reg[DIV_W-1]};
    assign div_ge    = (rem_shift >= {1'b0, dvsr_reg});

    // One shift-add multiply step
    assign acc_step = acc_reg + (my_reg[0] ? mx_reg : {ACC_W{1'b0}});

    // Quotient clamped to the time width
    assign quot_sat = (|dq_reg[DIV_W-1:TIME_W]) ? TIME_MAX : dq_reg[TIME_W-1:0];

    // Mean correction limited to the deviation
    assign q_mean   = (quot_sat > mag_reg) ? mag_reg : quot_sat;
    assign mean_upd = neg_reg ? (mean_reg - q_mean) : (mean_reg + q_mean);
    assign dev2     = neg_reg ? (mean_upd - fv_reg) : (fv_reg - mean_upd);

    // Clipping test operands
    assign ssk   = ss_reg * clip_k_reg;
    assign cmp_l = {{(CMP_W-ACC_W){1'b0}}, acc_reg} << SH_L;
    assign cmp_r = {{(CMP_W-SSK_W){1'b0}}, ssk} << SH_R;

    // Sum of squares increment, scaled and saturated
    assign ss_shifted = acc_reg >> SS_SHIFT;
    assign ss_inc     = (|ss_shifted[ACC_W-1:SS_W]) ? SS_MAX : ss_shifted[SS_W-1:0];
    assign ss_sum     = {1'b0, ss_reg} + {1'b0, ss_inc};

    // Saturating totals
    assign ev_sum   = {1'b0, events_reg} + {{(EVENT_W+1-COUNT_BITS){1'b0}}, event_count};
    assign kev_sum  = {1'b0, kevents_reg} + {{(EVENT_W+1-COUNT_BITS){1'b0}}, cnt_reg};
    assign tick_sum = {1'b0, ticks_reg}
                    + {{(TICK_W+1-DURATION_BITS){1'b0}}, duration_ticks};

    assign trivial_keep = !filter_enable_reg
                       || (dur_reg <= DURATION_BITS'(1))
                       || neg_reg
                       || (kcalls_reg <= CALL_W'(2))
                       || (ss_reg <= SS_ONE);

    assign snap_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Sequencer and datapath next values
    always_comb
    begin
        state_next         = state_reg;
        iter_next          = iter_reg;
        out_valid_next     = out_valid_reg && out_stall;
        filter_enable_next = filter_enable_reg;
        clip_k_next        = clip_k_reg;
        calls_next         = calls_reg;
        events_next        = events_reg;
        ticks_next         = ticks_reg;
        min_next           = min_reg;
        max_next           = max_reg;
        kcalls_next        = kcalls_reg;
        kevents_next       = kevents_reg;
        mean_next          = mean_reg;
        ss_next            = ss_reg;
        dur_next           = dur_reg;
        cnt_next           = cnt_reg;
        fv_next            = fv_reg;
        mag_next           = mag_reg;
        neg_next           = neg_reg;
        newcnt_next        = newcnt_reg;
        kept_next          = kept_reg;
        dq_next            = dq_reg;
        rem_next           = rem_reg;
        dvsr_next          = dvsr_reg;
        mx_next            = mx_reg;
        my_next            = my_reg;
        acc_next           = acc_reg;

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_FILTER_ENABLE)
            begin
                filter_enable_next = cfg_data[0];
            end
            else
            begin
                clip_k_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    dur_next  = duration_ticks;
                    cnt_next  = event_count;
                    kept_next = 1'b0;
                    if (command == CMD_CLEAR)
                    begin
                        calls_next   = '0;
                        events_next  = '0;
                        ticks_next   = '0;
                        min_next     = TIME_MAX;
                        max_next     = '0;
                        kcalls_next  = '0;
                        kevents_next = '0;
                        mean_next    = '0;
                        ss_next      = '0;
                        state_next   = S_DONE;
                    end
                    else if (event_count == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // raw totals, then start the per-event divide
                        calls_next  = (calls_reg == CALL_MAX) ? CALL_MAX : calls_reg + 1'b1;
                        events_next = ev_sum[EVENT_W] ? EVENT_MAX : ev_sum[EVENT_W-1:0];
                        ticks_next  = tick_sum[TICK_W] ? TICK_MAX : tick_sum[TICK_W-1:0];
                        dq_next     = {{(DIV_W-DURATION_BITS){1'b0}}, duration_ticks}
                                      << FRACTION_BITS;
                        rem_next    = '0;
                        dvsr_next   = {{(EVENT_W-COUNT_BITS){1'b0}}, event_count};
                        iter_next   = ITER_W'(DIV_W);
                        state_next  = S_DIV1;
                    end
                end
            end

            S_DIV1, S_DIV2:
            begin
                if (iter_reg != '0)
                begin
                    rem_next  = div_ge ? (rem_shift - {1'b0, dvsr_reg}) : rem_shift;
                    dq_next   = {dq_reg[DIV_W-2:0], div_ge};
                    iter_next = iter_reg - 1'b1;
                end
                else if (state_reg == S_DIV1)
                begin
                    // per-event time, extremes and deviation from the mean
                    fv_next = quot_sat;
                    if (quot_sat < min_reg)
                    begin
                        min_next = quot_sat;
                    end
                    if (quot_sat > max_reg)
                    begin
                        max_next = quot_sat;
                    end
                    neg_next   = (quot_sat < mean_reg);
                    mag_next   = (quot_sat < mean_reg) ? (mean_reg - quot_sat)
                                                       : (quot_sat - mean_reg);
                    state_next = S_FILT;
                end
                else
                begin
                    // move the mean, then form |dev| * |dev2|
                    mean_next  = mean_upd;
                    mx_next    = {{(ACC_W-TIME_W){1'b0}}, mag_reg};
                    my_next    = dev2;
                    acc_next   = '0;
                    iter_next  = ITER_W'(TIME_W);
                    state_next = S_MULD;
                end
            end

            S_FILT:
            begin
                if (trivial_keep)
                begin
                    state_next = S_KEEP;
                end
                else
                begin
                    mx_next    = {{(ACC_W-TIME_W){1'b0}}, mag_reg};
                    my_next    = mag_reg;
                    acc_next   = '0;
                    iter_next  = ITER_W'(TIME_W);
                    state_next = S_MULA;
                end
            end

            S_MULA, S_MULB, S_MULC, S_MULD, S_MULE:
            begin
                if (iter_reg != '0)
                begin
                    acc_next  = acc_step;
                    mx_next   = {mx_reg[ACC_W-2:0], 1'b0};
                    my_next   = {1'b0, my_reg[MY_W-1:1]};
                    iter_next = iter_reg - 1'b1;
                end
                else
                begin
                    case (state_reg)
                        S_MULA:
                        begin
                            mx_next    = acc_reg;
                            my_next    = {{(MY_W-EVENT_W){1'b0}}, kevents_reg};
                            acc_next   = '0;
                            iter_next  = ITER_W'(EVENT_W);
                            state_next = S_MULB;
                        end
                        S_MULB:
                        begin
                            state_next = S_CMP;
                        end
                        S_MULC:
                        begin
                            dq_next    = acc_reg[DIV_W-1:0];
                            rem_next   = '0;
                            dvsr_next  = newcnt_reg;
                            iter_next  = ITER_W'(DIV_W);
                            state_next = S_DIV2;
                        end
                        S_MULD:
                        begin
                            mx_next    = acc_reg;
                            my_next    = {{(MY_W-COUNT_BITS){1'b0}}, cnt_reg};
                            acc_next   = '0;
                            iter_next  = ITER_W'(COUNT_BITS);
                            state_next = S_MULE;
                        end
                        default:
                        begin
                            // fold in the weighted square and commit the sample
                            ss_next      = ss_sum[SS_W] ? SS_MAX : ss_sum[SS_W-1:0];
                            kevents_next = newcnt_reg;
                            kept_next    = 1'b1;
                            state_next   = S_DONE;
                        end
                    endcase
                end
            end

            S_CMP:
            begin
                state_next = (cmp_l < cmp_r) ? S_KEEP : S_DONE;
            end

            S_KEEP:
            begin
                newcnt_next = kev_sum[EVENT_W] ? EVENT_MAX : kev_sum[EVENT_W-1:0];
                kcalls_next = (kcalls_reg == CALL_MAX) ? CALL_MAX : kcalls_reg + 1'b1;
                mx_next     = {{(ACC_W-TIME_W){1'b0}}, mag_reg};
                my_next     = {{(MY_W-COUNT_BITS){1'b0}}, cnt_reg};
                acc_next    = '0;
                iter_next   = ITER_W'(COUNT_BITS);
                state_next  = S_MULC;
            end

            S_DONE:
            begin
                if (snap_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            iter_reg          <= '0;
            out_valid_reg     <= 1'b0;
            filter_enable_reg <= FILTER_ENABLE_RST;
            clip_k_reg        <= CLIP_K_RST;
            calls_reg         <= '0;
            events_reg        <= '0;
            ticks_reg         <= '0;
            min_reg           <= TIME_MAX;
            max_reg           <= '0;
            kcalls_reg        <= '0;
            kevents_reg       <= '0;
            mean_reg          <= '0;
            ss_reg            <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            iter_reg          <= iter_next;
            out_valid_reg     <= out_valid_next;
            filter_enable_reg <= filter_enable_next;
            clip_k_reg        <= clip_k_next;
            calls_reg         <= calls_next;
            events_reg        <= events_next;
            ticks_reg         <= ticks_next;
            min_reg           <= min_next;
            max_reg           <= max_next;
            kcalls_reg        <= kcalls_next;
            kevents_reg       <= kevents_next;
            mean_reg          <= mean_next;
            ss_reg            <= ss_next;
        end
    end

    // Working registers of the serial unit
    always_ff @(posedge clk)
    begin
        dur_reg    <= dur_next;
        cnt_reg    <= cnt_next;
        fv_reg     <= fv_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        newcnt_reg <= newcnt_next;
        kept_reg   <= kept_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        dvsr_reg   <= dvsr_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        acc_reg    <= acc_next;
    end

    // Capture the report
    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            r_calls_reg   <= calls_reg;
            r_events_reg  <= events_reg;
            r_ticks_reg   <= ticks_reg;
            r_min_reg     <= min_reg;
            r_max_reg     <= max_reg;
            r_kcalls_reg  <= kcalls_reg;
            r_kevents_reg <= kevents_reg;
            r_mean_reg    <= mean_reg;
            r_ss_reg      <= ss_reg;
            r_kept_reg    <= kept_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign report_calls       = r_calls_reg;
    assign report_events      = r_events_reg;
    assign report_ticks       = r_ticks_reg;
    assign report_min         = r_min_reg;
    assign report_max         = r_max_reg;
    assign report_kept_calls  = r_kcalls_reg;
    assign report_kept_events = r_kevents_reg;
    assign report_mean        = r_mean_reg;
    assign report_sum_squares = r_ss_reg;
    assign sample_kept        = r_kept_reg;

endmodule

`default_nettype wire
